### rtl/core/weo_pkg.sv
// Shared types, constants and helpers for the wheel encoder odometry block.
package weo_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_PULSE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREES_PER_DIFF = 1'd1;

  // Velocity scale: 1 / (1e-6 s per us / 2 half-us per sum) = 2000000
  localparam logic [31:0] VEL_SCALE = 32'd2000000;

  // Rounding addends, half an LSB after the final shift
  localparam logic [63:0] RND_DISP = 64'h0000_0000_0001_0000;
  localparam logic [63:0] RND_ROT  = 64'h0000_0000_0000_0080;

  // Clip bounds for a signed 32-bit result, as magnitudes
  localparam logic [55:0] MAG_NEG_LIMIT = 56'h00_0000_8000_0000;
  localparam logic [55:0] MAG_POS_LIMIT = 56'h00_0000_7FFF_FFFF;
  localparam logic [55:0] MAG_OVERFLOW  = 56'h00_0001_0000_0000;

  // Which quantity the datapath works on
  typedef enum logic [1:0] {
    PH_DISP = 2'd0,
    PH_ROT  = 2'd1,
    PH_VEL  = 2'd2
  } phase_t;

  // Accumulator operations
  typedef enum logic [1:0] {
    ACC_HOLD   = 2'd0,
    ACC_LOAD   = 2'd1,
    ACC_ADD_HI = 2'd2,
    ACC_ROUND  = 2'd3
  } acc_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    setup;
    phase_t  phase;
    logic    mul_hi;
    acc_op_t acc_op;
    logic    div_load;
    logic    div_step;
    logic    fin_en;
    logic    out_load;
  } weo_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_div;
    logic div_done;
  } weo_status_t;

  typedef struct packed {
    logic [31:0] value;
    logic        hit;
  } clip_t;

  // Turn a magnitude and sign into a saturated signed 32-bit value
  function automatic clip_t clip32(input logic [55:0] mag, input logic neg);
    clip_t res;
    res.hit   = 1'b0;
    res.value = mag[31:0];
    if (neg) begin
      if (mag > MAG_NEG_LIMIT) begin
        res.hit   = 1'b1;
        res.value = 32'h8000_0000;
      end else begin
        res.value = (~mag[31:0]) + 32'd1;
      end
    end else if (mag > MAG_POS_LIMIT) begin
      res.hit   = 1'b1;
      res.value = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

### rtl/core/wheel_encoder_odometry.sv
// Top level of the differential-drive wheel encoder odometry block.
//
//  channel  direction  handshake             payload
//  in       to block   in_valid / in_stall   pulse totals, timestamps
//  out      from block out_valid / out_stall displacement, rotation, velocity, flags
//  cfg      to block   cfg_valid / cfg_ready register index, write data
//
//  An item passes from its input beat to its result through the 32-step restoring
//  divider and the shared 33x16 multiplier, used twice for each of three products;
//  the divider is skipped when the elapsed time is zero or the velocity quotient
//  would not fit in 32 bits.
//  One item is in work at a time; the next is taken while a result waits in the
//  output register. rst_n is synchronous: it clears configuration, history and control.
//  A stalled result holds the output register; the sequencer then waits before
//  loading the next one.
module wheel_encoder_odometry (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_left_pulse_total,
  input  logic signed [31:0]            in_right_pulse_total,
  input  logic [31:0]                   in_left_time_us,
  input  logic [31:0]                   in_right_time_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_displacement_q16,
  output logic signed [31:0]            out_rotation_q16,
  output logic signed [31:0]            out_velocity_q16,
  output logic                          out_velocity_valid,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [weo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  weo_pkg::weo_cmd_t    cmd;
  weo_pkg::weo_status_t status;
  logic [31:0]          disp, rot, vel;
  logic                 cfg_we;

  // Accept configuration writes at any time
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign out_displacement_q16 = $signed(disp);
  assign out_rotation_q16     = $signed(rot);
  assign out_velocity_q16     = $signed(vel);

  weo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  weo_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_left       ($unsigned(in_left_pulse_total)),
    .in_right      ($unsigned(in_right_pulse_total)),
    .in_left_time  (in_left_time_us),
    .in_right_time (in_right_time_us),
    .out_disp      (disp),
    .out_rot       (rot),
    .out_vel       (vel),
    .out_vel_valid (out_velocity_valid),
    .out_sat       (out_saturated)
  );

endmodule

### rtl/core/weo_ctrl.sv
// Sequencer for the wheel encoder odometry block: handshakes and step order.
module weo_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  weo_pkg::weo_status_t status,
  output weo_pkg::weo_cmd_t    cmd
);

  typedef enum logic [19:0] {
    ST_IDLE  = 20'h00001,
    ST_SETUP = 20'h00002,
    ST_D_LO  = 20'h00004,
    ST_D_HI  = 20'h00008,
    ST_D_ACC = 20'h00010,
    ST_D_RND = 20'h00020,
    ST_D_FIN = 20'h00040,
    ST_R_LO  = 20'h00080,
    ST_R_HI  = 20'h00100,
    ST_R_ACC = 20'h00200,
    ST_R_RND = 20'h00400,
    ST_R_FIN = 20'h00800,
    ST_V_LO  = 20'h01000,
    ST_V_HI  = 20'h02000,
    ST_V_ACC = 20'h04000,
    ST_V_RND = 20'h08000,
    ST_V_CHK = 20'h10000,
    ST_V_DIV = 20'h20000,
    ST_V_FIN = 20'h40000,
    ST_PUSH  = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.phase    = weo_pkg::PH_DISP;
    cmd.acc_op   = weo_pkg::ACC_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_D_LO;
      end
      // displacement: low half product, high half, merge, round, clip
      ST_D_LO: begin
        state_nxt = ST_D_HI;
      end
      ST_D_HI: begin
        cmd.mul_hi = 1'b1;
        cmd.acc_op = weo_pkg::ACC_LOAD;
        state_nxt  = ST_D_ACC;
      end
      ST_D_ACC: begin
        cmd.acc_op = weo_pkg::ACC_ADD_HI;
        state_nxt  = ST_D_RND;
      end
      ST_D_RND: begin
        cmd.acc_op = weo_pkg::ACC_ROUND;
        state_nxt  = ST_D_FIN;
      end
      ST_D_FIN: begin
        cmd.fin_en = 1'b1;
        state_nxt  = ST_R_LO;
      end
      // rotation
      ST_R_LO: begin
        cmd.phase = weo_pkg::PH_ROT;
        state_nxt = ST_R_HI;
      end
      ST_R_HI: begin
        cmd.phase  = weo_pkg::PH_ROT;
        cmd.mul_hi = 1'b1;
        cmd.acc_op = weo_pkg::ACC_LOAD;
        state_nxt  = ST_R_ACC;
      end
      ST_R_ACC: begin
        cmd.phase  = weo_pkg::PH_ROT;
        cmd.acc_op = weo_pkg::ACC_ADD_HI;
        state_nxt  = ST_R_RND;
      end
      ST_R_RND: begin
        cmd.phase  = weo_pkg::PH_ROT;
        cmd.acc_op = weo_pkg::ACC_ROUND;
        state_nxt  = ST_R_FIN;
      end
      ST_R_FIN: begin
        cmd.phase  = weo_pkg::PH_ROT;
        cmd.fin_en = 1'b1;
        state_nxt  = ST_V_LO;
      end
      // velocity: scale displacement, add half divisor, divide
      ST_V_LO: begin
        cmd.phase = weo_pkg::PH_VEL;
        state_nxt = ST_V_HI;
      end
      ST_V_HI: begin
        cmd.phase  = weo_pkg::PH_VEL;
        cmd.mul_hi = 1'b1;
        cmd.acc_op = weo_pkg::ACC_LOAD;
        state_nxt  = ST_V_ACC;
      end
      ST_V_ACC: begin
        cmd.phase  = weo_pkg::PH_VEL;
        cmd.acc_op = weo_pkg::ACC_ADD_HI;
        state_nxt  = ST_V_RND;
      end
      ST_V_RND: begin
        cmd.phase  = weo_pkg::PH_VEL;
        cmd.acc_op = weo_pkg::ACC_ROUND;
        state_nxt  = ST_V_CHK;
      end
      ST_V_CHK: begin
        cmd.phase    = weo_pkg::PH_VEL;
        cmd.div_load = 1'b1;
        state_nxt    = status.skip_div ? ST_V_FIN : ST_V_DIV;
      end
      ST_V_DIV: begin
        cmd.phase    = weo_pkg::PH_VEL;
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_V_FIN;
        end
      end
      ST_V_FIN: begin
        cmd.phase  = weo_pkg::PH_VEL;
        cmd.fin_en = 1'b1;
        state_nxt  = ST_PUSH;
      end
      // hand the result to the output register once it is free
      ST_PUSH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the output beat until taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/weo_dp.sv
// Datapath of the wheel encoder odometry block: history, multiplier, divider, results.
module weo_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  weo_pkg::weo_cmd_t             cmd,
  output weo_pkg::weo_status_t          status,
  input  logic                          cfg_we,
  input  logic [weo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [31:0]                   in_left,
  input  logic [31:0]                   in_right,
  input  logic [31:0]                   in_left_time,
  input  logic [31:0]                   in_right_time,
  output logic [31:0]                   out_disp,
  output logic [31:0]                   out_rot,
  output logic [31:0]                   out_vel,
  output logic                          out_vel_valid,
  output logic                          out_sat
);

  // configuration and history
  logic [31:0] mpp_r, dppd_r;
  logic [31:0] prev_left_r, prev_right_r;
  logic [32:0] prev_sum_r;

  // per-item working registers
  logic [31:0] dl_r, dr_r;
  logic [32:0] h_r;
  logic [32:0] dsum_mag_r, ddif_mag_r;
  logic        dsum_neg_r, ddif_neg_r;
  logic [48:0] prod_r;
  logic [63:0] acc_r, acc_nxt;
  logic [32:0] rem_r;
  logic [31:0] q_r;
  logic [4:0]  div_cnt_r;
  logic        ovf_r;
  logic [31:0] disp_r, disp_mag_r, rot_r, vel_r;
  logic        vel_valid_r, sat_r;

  // combinational helpers
  logic [32:0] tsum;
  logic [32:0] dsum, ddif;
  logic [32:0] mul_a;
  logic [15:0] mul_b;
  logic [63:0] rnd_add;
  logic        h_zero;
  logic        ovf_c;
  logic [33:0] trial;
  logic [55:0] fin_mag;
  logic        fin_neg;
  weo_pkg::clip_t fin_clip;

  assign tsum   = {1'b0, in_left_time} + {1'b0, in_right_time};
  assign dsum   = {dl_r[31], dl_r} + {dr_r[31], dr_r};
  assign ddif   = {dr_r[31], dr_r} - {dl_r[31], dl_r};
  assign h_zero = (h_r == '0);
  assign ovf_c  = ({1'b0, acc_r[63:32]} >= h_r);
  assign trial  = {rem_r, q_r[31]} - {1'b0, h_r};

  assign status.skip_div = h_zero || ovf_c;
  assign status.div_done = (div_cnt_r == '1);

  // Select multiplier operands
  always_comb begin
    case (cmd.phase)
      weo_pkg::PH_DISP: begin
        mul_a = dsum_mag_r;
        mul_b = cmd.mul_hi ? mpp_r[31:16] : mpp_r[15:0];
      end
      weo_pkg::PH_ROT: begin
        mul_a = ddif_mag_r;
        mul_b = cmd.mul_hi ? dppd_r[31:16] : dppd_r[15:0];
      end
      weo_pkg::PH_VEL: begin
        mul_a = {1'b0, disp_mag_r};
        mul_b = cmd.mul_hi ? weo_pkg::VEL_SCALE[31:16] : weo_pkg::VEL_SCALE[15:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Select rounding addend
  always_comb begin
    case (cmd.phase)
      weo_pkg::PH_DISP: rnd_add = weo_pkg::RND_DISP;
      weo_pkg::PH_ROT:  rnd_add = weo_pkg::RND_ROT;
      weo_pkg::PH_VEL:  rnd_add = {32'd0, h_r[32:1]};
      default:          rnd_add = '0;
    endcase
  end

  // Accumulate the two partial products, then add the rounding term
  always_comb begin
    case (cmd.acc_op)
      weo_pkg::ACC_HOLD:   acc_nxt = acc_r;
      weo_pkg::ACC_LOAD:   acc_nxt = {15'd0, prod_r};
      weo_pkg::ACC_ADD_HI: acc_nxt = acc_r + {prod_r[47:0], 16'd0};
      weo_pkg::ACC_ROUND:  acc_nxt = acc_r + rnd_add;
      default:             acc_nxt = acc_r;
    endcase
  end

  // Pick the magnitude to saturate
  always_comb begin
    case (cmd.phase)
      weo_pkg::PH_DISP: begin
        fin_mag = {9'd0, acc_r[63:17]};
        fin_neg = dsum_neg_r;
      end
      weo_pkg::PH_ROT: begin
        fin_mag = acc_r[63:8];
        fin_neg = ddif_neg_r;
      end
      weo_pkg::PH_VEL: begin
        if (h_zero) begin
          fin_mag = '0;
          fin_neg = 1'b0;
        end else if (ovf_r) begin
          fin_mag = weo_pkg::MAG_OVERFLOW;
          fin_neg = dsum_neg_r;
        end else begin
          fin_mag = {24'd0, q_r};
          fin_neg = dsum_neg_r;
        end
      end
      default: begin
        fin_mag = '0;
        fin_neg = 1'b0;
      end
    endcase
    fin_clip = weo_pkg::clip32(fin_mag, fin_neg);
  end

  // Configuration and encoder history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpp_r        <= '0;
      dppd_r       <= '0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      prev_sum_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          weo_pkg::CFG_METERS_PER_PULSE: mpp_r  <= cfg_data;
          weo_pkg::CFG_DEGREES_PER_DIFF: dppd_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        prev_left_r  <= in_left;
        prev_right_r <= in_right;
        prev_sum_r   <= tsum;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    // take increments and elapsed time on the input beat
    if (cmd.capture) begin
      dl_r  <= in_left - prev_left_r;
      dr_r  <= in_right - prev_right_r;
      h_r   <= tsum - prev_sum_r;
      sat_r <= 1'b0;
    end
    // split sum and difference into magnitude and sign
    if (cmd.setup) begin
      dsum_neg_r <= dsum[32];
      dsum_mag_r <= dsum[32] ? (~dsum + 33'd1) : dsum;
      ddif_neg_r <= ddif[32];
      ddif_mag_r <= ddif[32] ? (~ddif + 33'd1) : ddif;
    end
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
    // restoring divider, one quotient bit a cycle
    if (cmd.div_load) begin
      rem_r     <= {1'b0, acc_r[63:32]};
      q_r       <= acc_r[31:0];
      ovf_r     <= ovf_c;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[33]) begin
        rem_r <= trial[32:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], q_r[31]};
        q_r   <= {q_r[30:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r + 5'd1;
    end
    // store saturated results
    if (cmd.fin_en) begin
      if (fin_clip.hit) begin
        sat_r <= 1'b1;
      end
      case (cmd.phase)
        weo_pkg::PH_DISP: begin
          disp_r     <= fin_clip.value;
          disp_mag_r <= fin_clip.hit ? (dsum_neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                     : fin_mag[31:0];
        end
        weo_pkg::PH_ROT: rot_r <= fin_clip.value;
        weo_pkg::PH_VEL: begin
          vel_r       <= fin_clip.value;
          vel_valid_r <= !h_zero;
        end
        default: ;
      endcase
    end
    // output register
    if (cmd.out_load) begin
      out_disp      <= disp_r;
      out_rot       <= rot_r;
      out_vel       <= vel_r;
      out_vel_valid <= vel_valid_r;
      out_sat       <= sat_r;
    end
  end

endmodule
